/* sv/biba_pkg.sv */
// biba_pkg: shared types, codes and constants of the bitmap inode/block allocator
// used by biba_ctrl, biba_datapath, biba_checker and the top level
// no dependencies
package biba_pkg;

  localparam int CNT_W     = 13;
  localparam int IDX_W     = 12;
  localparam int MODE_W    = 3;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int WORD_W    = 64;
  localparam int WORD_SH   = 6;

  // command codes
  localparam logic [MODE_W-1:0] MODE_RES_INODE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REL_INODE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RES_BLOCK = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REL_BLOCK = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FORMAT    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_NONE      = 3'd7;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INODE_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TOTAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED    = 2'd2;

  localparam logic [CNT_W-1:0] INODE_TOTAL_RST = 13'd1024;
  localparam logic [CNT_W-1:0] BLOCK_TOTAL_RST = 13'd4096;
  localparam logic [CNT_W-1:0] RESERVED_RST    = 13'd36;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ISSUE,
    S_SCAN,
    S_REL,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SRC_HINT,
    SRC_IDX,
    SRC_NEXT
  } rd_src_t;

  typedef struct packed {
    logic    load;
    logic    sel_block;
    logic    fmt_latch;
    logic    clr_step;
    logic    rd_issue;
    rd_src_t rd_src;
    logic    scan;
    logic    take;
    logic    give_back;
  } ctl_t;

  typedef struct packed {
    logic pool_empty;
    logic out_of_range;
    logic found;
    logic at_last;
    logic clr_last;
  } dp_stat_t;

  function automatic logic [CNT_W-1:0] pool_size(input logic [CNT_W-1:0] total,
                                                 input logic [CNT_W-1:0] cap);
    return (total > cap) ? cap : total;
  endfunction

endpackage

/* sv/biba_ctrl.sv */
// biba_ctrl: command sequencer of the allocator (clear pass, scan, release, result)
// depends on biba_pkg; drives biba_datapath through ctl_t, reads dp_stat_t
module biba_ctrl
  import biba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MODE_W-1:0] mode,
  input  dp_stat_t          dp,
  output ctl_t              ctl,
  output logic              busy,
  output logic              done,
  output logic [STAT_W-1:0] status
);

  state_t            state;
  state_t            state_next;
  logic [MODE_W-1:0] op_q;
  logic [STAT_W-1:0] stat_q;
  logic              stat_set;
  logic [STAT_W-1:0] stat_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      op_q   <= MODE_NONE;
      stat_q <= STAT_OK;
    end else begin
      state <= state_next;
      if (ctl.load) begin
        op_q <= mode;
      end
      if (stat_set) begin
        stat_q <= stat_code;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (dp.clr_last) begin
          state_next = (op_q == MODE_FORMAT) ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = (mode == MODE_FORMAT) ? S_CLEAR : S_ISSUE;
        end
      end
      S_ISSUE: begin
        case (op_q) inside
          MODE_RES_INODE, MODE_RES_BLOCK: begin
            state_next = dp.pool_empty ? S_DONE : S_SCAN;
          end
          MODE_REL_INODE, MODE_REL_BLOCK: begin
            state_next = dp.out_of_range ? S_DONE : S_REL;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (dp.found || dp.at_last) begin
          state_next = S_DONE;
        end
      end
      S_REL: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl           = '0;
    ctl.rd_src    = SRC_HINT;
    ctl.sel_block = (op_q == MODE_RES_BLOCK) || (op_q == MODE_REL_BLOCK);
    stat_set      = 1'b0;
    stat_code     = STAT_OK;
    busy          = 1'b1;
    done          = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load      = 1'b1;
          stat_set      = 1'b1;
          stat_code     = STAT_OK;
          ctl.fmt_latch = (mode == MODE_FORMAT);
        end
      end
      S_ISSUE: begin
        case (op_q) inside
          MODE_RES_INODE, MODE_RES_BLOCK: begin
            if (dp.pool_empty) begin
              stat_set  = 1'b1;
              stat_code = STAT_EMPTY;
            end else begin
              ctl.rd_issue = 1'b1;
              ctl.rd_src   = SRC_HINT;
            end
          end
          MODE_REL_INODE, MODE_REL_BLOCK: begin
            if (dp.out_of_range) begin
              stat_set  = 1'b1;
              stat_code = STAT_RANGE;
            end else begin
              ctl.rd_issue = 1'b1;
              ctl.rd_src   = SRC_IDX;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (dp.found) begin
          ctl.take = 1'b1;
        end else if (dp.at_last) begin
          stat_set  = 1'b1;
          stat_code = STAT_EMPTY;
        end else begin
          ctl.rd_issue = 1'b1;
          ctl.rd_src   = SRC_NEXT;
        end
      end
      S_REL: begin
        ctl.give_back = 1'b1;
      end
      S_DONE: begin
        done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign status = stat_q;

endmodule

/* sv/biba_datapath.sv */
// biba_datapath: bitmap word memories, free counters, scan hints and registers
// depends on biba_pkg; controlled by biba_ctrl through ctl_t
module biba_datapath
  import biba_pkg::*;
#(
  parameter int MAP_ENTRIES = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  input  logic [IDX_W-1:0]     entry_index,
  input  ctl_t                 ctl,
  output dp_stat_t             dp,
  output logic [IDX_W-1:0]     granted_index,
  output logic [CNT_W-1:0]     inode_avail,
  output logic [CNT_W-1:0]     block_avail
);

  localparam int WORDS   = (MAP_ENTRIES + WORD_W - 1) / WORD_W;
  localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int HW      = AW + 1;
  localparam int PW      = AW + WORD_SH + 1;
  localparam int MAP_CAP = (MAP_ENTRIES > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1 : MAP_ENTRIES;
  localparam logic [CNT_W-1:0] CAP       = CNT_W'(MAP_CAP);
  localparam logic [CNT_W-1:0] RST_ISIZE = pool_size(INODE_TOTAL_RST, CAP);
  localparam logic [CNT_W-1:0] RST_BSIZE = pool_size(BLOCK_TOTAL_RST, CAP);
  localparam logic [CNT_W-1:0] RST_NR    = pool_size(RESERVED_RST, CAP);
  localparam logic [CNT_W-1:0] RST_ICNT  =
    (RST_ISIZE != '0) ? CNT_W'(RST_ISIZE - CNT_W'(1)) : '0;
  localparam logic [CNT_W-1:0] RST_BCNT  =
    (RST_BSIZE > RST_NR) ? CNT_W'(RST_BSIZE - RST_NR) : '0;

  logic [WORD_W-1:0] inode_mem [WORDS];
  logic [WORD_W-1:0] block_mem [WORDS];

  logic [CNT_W-1:0]   inode_total;
  logic [CNT_W-1:0]   block_total;
  logic [CNT_W-1:0]   reserved_blocks;
  logic [CNT_W-1:0]   free_i;
  logic [CNT_W-1:0]   free_b;
  logic [HW-1:0]      hint_i;
  logic [HW-1:0]      hint_b;
  logic [CNT_W-1:0]   fmt_nr;
  logic [AW-1:0]      clr;
  logic [AW-1:0]      dptr;
  logic [IDX_W-1:0]   idx_q;
  logic [IDX_W-1:0]   granted;
  logic [WORD_W-1:0]  i_rdata;
  logic [WORD_W-1:0]  b_rdata;

  logic [CNT_W-1:0]   isize;
  logic [CNT_W-1:0]   bsize;
  logic [CNT_W-1:0]   nr_live;
  logic [CNT_W-1:0]   icnt_live;
  logic [CNT_W-1:0]   bcnt_live;
  logic [CNT_W-1:0]   size_sel;
  logic [CNT_W-1:0]   cnt_sel;
  logic [HW-1:0]      hint_sel;
  logic [WORD_W-1:0]  rdata_sel;
  logic [CNT_W-1:0]   last_word;
  logic [CNT_W-1:0]   lim;
  logic [WORD_W-1:0]  valid_mask;
  logic [WORD_W-1:0]  seen;
  logic [WORD_SH-1:0] fz_pos;
  logic [WORD_W-1:0]  fz_hot;
  logic [WORD_W-1:0]  scan_word;
  logic [AW-1:0]      idx_word;
  logic [WORD_W-1:0]  idx_hot;
  logic [AW-1:0]      raddr;
  logic [PW-1:0]      base_p;
  logic [PW-1:0]      nr_p;
  logic [PW-1:0]      nr_off;
  logic [WORD_W-1:0]  i_pat;
  logic [WORD_W-1:0]  b_pat;
  logic               i_we;
  logic               b_we;
  logic [AW-1:0]      waddr;
  logic [WORD_W-1:0]  upd_word;
  logic [WORD_W-1:0]  i_wdata;
  logic [WORD_W-1:0]  b_wdata;
  logic [CNT_W-1:0]   cnt_new;
  logic [HW-1:0]      hint_new;

  assign isize     = pool_size(inode_total, CAP);
  assign bsize     = pool_size(block_total, CAP);
  assign nr_live   = pool_size(reserved_blocks, CAP);
  assign icnt_live = (isize != '0) ? isize - CNT_W'(1) : '0;
  assign bcnt_live = (bsize > nr_live) ? bsize - nr_live : '0;

  assign size_sel  = ctl.sel_block ? bsize : isize;
  assign cnt_sel   = ctl.sel_block ? free_b : free_i;
  assign hint_sel  = ctl.sel_block ? hint_b : hint_i;
  assign rdata_sel = ctl.sel_block ? b_rdata : i_rdata;

  // last word holding entries below the pool size
  assign last_word = (size_sel - CNT_W'(1)) >> WORD_SH;

  // bits at or beyond the pool size count as used
  always_comb begin
    lim = size_sel - CNT_W'({dptr, {WORD_SH{1'b0}}});
    if (lim >= CNT_W'(WORD_W)) begin
      valid_mask = '1;
    end else begin
      valid_mask = ~({WORD_W{1'b1}} << lim[WORD_SH-1:0]);
    end
    seen = rdata_sel | ~valid_mask;
  end

  // lowest clear bit of the scanned word
  always_comb begin
    fz_pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!seen[b]) begin
        fz_pos = WORD_SH'(b);
      end
    end
  end

  assign fz_hot    = WORD_W'(1) << fz_pos;
  assign scan_word = (~&seen) ? (rdata_sel | fz_hot) : rdata_sel;
  assign idx_word  = AW'(idx_q >> WORD_SH);
  assign idx_hot   = WORD_W'(1) << idx_q[WORD_SH-1:0];

  always_comb begin
    raddr = dptr;
    unique case (ctl.rd_src)
      SRC_HINT: raddr = AW'(hint_sel);
      SRC_IDX:  raddr = idx_word;
      SRC_NEXT: raddr = dptr + AW'(1);
      default:  raddr = dptr;
    endcase
  end

  // format patterns: inode zero used, leading reserved blocks used
  always_comb begin
    base_p = PW'({clr, {WORD_SH{1'b0}}});
    nr_p   = PW'(fmt_nr);
    nr_off = nr_p - base_p;
    if (nr_p >= base_p + PW'(WORD_W)) begin
      b_pat = '1;
    end else if (nr_p > base_p) begin
      b_pat = ~({WORD_W{1'b1}} << nr_off[WORD_SH-1:0]);
    end else begin
      b_pat = '0;
    end
    i_pat = (clr == '0) ? WORD_W'(1) : '0;
  end

  always_comb begin
    i_we     = ctl.clr_step || ((ctl.take || ctl.give_back) && !ctl.sel_block);
    b_we     = ctl.clr_step || ((ctl.take || ctl.give_back) && ctl.sel_block);
    waddr    = ctl.clr_step ? clr : dptr;
    upd_word = ctl.take ? scan_word : (rdata_sel & ~idx_hot);
    i_wdata  = ctl.clr_step ? i_pat : upd_word;
    b_wdata  = ctl.clr_step ? b_pat : upd_word;
  end

  // words below the hint are known to be completely used
  always_comb begin
    if (ctl.take) begin
      cnt_new = cnt_sel - CNT_W'(1);
    end else begin
      cnt_new = (cnt_sel < size_sel) ? cnt_sel + CNT_W'(1) : cnt_sel;
    end
    if (ctl.give_back) begin
      hint_new = (hint_sel > HW'(dptr)) ? HW'(dptr) : hint_sel;
    end else begin
      hint_new = ((&scan_word) && (hint_sel == HW'(dptr))) ? HW'(dptr) + HW'(1) : hint_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (i_we) begin
      inode_mem[waddr] <= i_wdata;
    end
    if (b_we) begin
      block_mem[waddr] <= b_wdata;
    end
    if (ctl.rd_issue) begin
      i_rdata <= inode_mem[raddr];
      b_rdata <= block_mem[raddr];
      dptr    <= raddr;
    end
    if (ctl.load) begin
      idx_q   <= entry_index;
      granted <= '0;
    end else if (ctl.take) begin
      granted <= IDX_W'({dptr, fz_pos});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inode_total     <= INODE_TOTAL_RST;
      block_total     <= BLOCK_TOTAL_RST;
      reserved_blocks <= RESERVED_RST;
      free_i          <= RST_ICNT;
      free_b          <= RST_BCNT;
      hint_i          <= '0;
      hint_b          <= '0;
      fmt_nr          <= RST_NR;
      clr             <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INODE_TOTAL: inode_total     <= cfg_data;
          CFG_BLOCK_TOTAL: block_total     <= cfg_data;
          CFG_RESERVED:    reserved_blocks <= cfg_data;
          default: begin
          end
        endcase
      end
      if (ctl.fmt_latch) begin
        free_i <= icnt_live;
        free_b <= bcnt_live;
        fmt_nr <= nr_live;
        hint_i <= '0;
        hint_b <= '0;
        clr    <= '0;
      end
      if (ctl.clr_step) begin
        clr <= clr + AW'(1);
      end
      if (ctl.take || ctl.give_back) begin
        if (ctl.sel_block) begin
          free_b <= cnt_new;
        end else begin
          free_i <= cnt_new;
        end
      end
      if (ctl.scan || ctl.give_back) begin
        if (ctl.sel_block) begin
          hint_b <= hint_new;
        end else begin
          hint_i <= hint_new;
        end
      end
    end
  end

  assign dp.pool_empty   = (cnt_sel == '0) || (size_sel == '0) ||
                           (CNT_W'(hint_sel) > last_word);
  assign dp.out_of_range = CNT_W'(idx_q) >= size_sel;
  assign dp.found        = ~&seen;
  assign dp.at_last      = CNT_W'(dptr) == last_word;
  assign dp.clr_last     = clr == AW'(WORDS - 1);

  assign granted_index = granted;
  assign inode_avail   = free_i;
  assign block_avail   = free_b;

endmodule

/* sv/bitmap_inode_block_allocator_unit.sv */
// bitmap_inode_block_allocator_unit: top level of the inode/block free-space allocator
// depends on biba_pkg, biba_ctrl and biba_datapath
//
// Usage:
//   command channel: an item is taken at a clock edge with start high and busy
//   low; mode picks reserve/release of an inode or block, or format, and
//   entry_index names the entry to release.
//   result channel: done is high for exactly one cycle with granted_index,
//   status, inode_avail and block_avail; the receiver cannot hold it off.
//   config port: cfg_we/cfg_index/cfg_data write inode_total, block_total and
//   reserved_blocks; pool sizes apply to the next item, the map layout and
//   counts only change at the next format.
// Sequence from the accepting edge to the done cycle:
//   an empty pool, out-of-range release or unused mode goes from issue to done;
//   a release passes the issue and release states before done;
//   a reserve scans 1 to (MAP_ENTRIES+63)/64 64-bit bitmap words, starting from a
//   per-pool hint past the full words;
//   a format clears the memories, one memory word cleared a cycle.
// busy falls the cycle after done, and the next item can then be accepted.
// Reset runs the same clearing pass: busy stays high while the memories are
// cleared and no result is produced for it.
module bitmap_inode_block_allocator_unit
  import biba_pkg::*;
#(
  parameter int MAP_ENTRIES = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [MODE_W-1:0]    mode,
  input  logic [IDX_W-1:0]     entry_index,
  output logic                 done,
  output logic [IDX_W-1:0]     granted_index,
  output logic [STAT_W-1:0]    status,
  output logic [CNT_W-1:0]     inode_avail,
  output logic [CNT_W-1:0]     block_avail,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  ctl_t     ctl;
  dp_stat_t dps;

  biba_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .dp     (dps),
    .ctl    (ctl),
    .busy   (busy),
    .done   (done),
    .status (status)
  );

  biba_datapath #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .entry_index   (entry_index),
    .ctl           (ctl),
    .dp            (dps),
    .granted_index (granted_index),
    .inode_avail   (inode_avail),
    .block_avail   (block_avail)
  );

endmodule

/* sv/biba_checker.sv */
// biba_checker: port-level assertions for the allocator, bound to the top level
// depends on biba_pkg and bitmap_inode_block_allocator_unit
module biba_checker
  import biba_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [IDX_W-1:0]  granted_index,
  input logic [STAT_W-1:0] status
);

  // a result only comes out of an item in flight
  a_done_busy : assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // one result per item; done is never held high
  a_done_single : assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // an accepted item keeps the block busy
  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low after accept");

  // failed commands grant nothing
  a_fail_zero : assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_OK) |-> granted_index == '0)
    else $error("nonzero index on failed command");

  a_status_code : assert property (@(posedge clk) disable iff (rst)
    done |-> (status == STAT_OK || status == STAT_EMPTY || status == STAT_RANGE))
    else $error("undefined status code");

endmodule

bind bitmap_inode_block_allocator_unit biba_checker u_biba_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .granted_index (granted_index),
  .status        (status)
);
